// ===== rtl/rme_pkg.sv =====
// Shared types, constants and helper functions for the rotation-matrix-to-Euler block.
package rme_pkg;

  // CORDIC datapath width; operands carry 2^48 per unit of the Q1.14 input
  localparam int CW = 54;
  localparam int ZW = 28;
  localparam int QW = 17;
  localparam int CORDIC_STEPS = 25;
  localparam int SQRT_STAGES = 29;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int PIPE_DEPTH = 2 + SQRT_STAGES + CORDIC_LAT;

  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [QW-1:0] PI_Q13 = 17'sd25736;
  localparam logic signed [QW-1:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic [14:0] THRESH_RESET = 15'd16351;
  localparam logic [31:0] ONE_Q28 = 32'd268435456;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  typedef struct packed {
    logic signed [16:0] xa;
    logic signed [16:0] xb;
    logic signed [16:0] za;
    logic signed [16:0] zb;
    logic signed [15:0] r10;
    pole_t              pole;
  } opnd_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] v;
    begin
      unique case (i)
        0: v = 28'sd13176795;
        1: v = 28'sd7778716;
        2: v = 28'sd4110060;
        3: v = 28'sd2086331;
        4: v = 28'sd1047214;
        5: v = 28'sd524117;
        6: v = 28'sd262123;
        7: v = 28'sd131069;
        8: v = 28'sd65536;
        default: v = ZW'(1 << (24 - i));
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [QW-1:0] clamp_q(input logic signed [QW-1:0] q,
                                                   input logic signed [QW-1:0] lim);
    logic signed [QW-1:0] r;
    begin
      if (q > lim) r = lim;
      else if (q < -lim) r = -lim;
      else r = q;
      return r;
    end
  endfunction

endpackage

// ===== rtl/rme_sqrt.sv =====
// Pipelined integer square root of rad * 2^28, one result bit per stage.
module rme_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [28:0] rad,
  output logic [28:0] root
);

  localparam int N = rme_pkg::SQRT_STAGES;

  logic [29:0] rem_r  [0:N-1];
  logic [28:0] root_r [0:N-1];
  logic [28:0] rad_r  [0:N-1];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [29:0] rem_p;
      logic [28:0] root_p;
      logic [28:0] rad_p;
      logic [57:0] v;
      logic [31:0] remc;
      logic [31:0] trial;
      logic        ge;
      if (k == 0) begin : g_first
        assign rem_p  = '0;
        assign root_p = '0;
        assign rad_p  = rad;
      end else begin : g_next
        assign rem_p  = rem_r[k-1];
        assign root_p = root_r[k-1];
        assign rad_p  = rad_r[k-1];
      end
      assign v     = {1'b0, rad_p, 28'd0};
      assign remc  = {rem_p, v[57-2*k -: 2]};
      assign trial = {1'b0, root_p, 2'b01};
      assign ge    = remc >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? 30'(remc - trial) : remc[29:0];
          root_r[k] <= {root_p[27:0], ge};
          rad_r[k]  <= rad_p;
        end
      end
    end
  endgenerate

  assign root = root_r[N-1];

endmodule

// ===== rtl/rme_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with quadrant pre-rotation and Q2.13 rounding.
module rme_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rme_pkg::CW-1:0]    a_in,
  input  logic signed [rme_pkg::CW-1:0]    b_in,
  output logic signed [rme_pkg::QW-1:0]    q
);

  localparam int W = rme_pkg::CW;
  localparam int N = rme_pkg::CORDIC_STEPS;

  logic signed [W-1:0]           x_r [0:N];
  logic signed [W-1:0]           y_r [0:N];
  logic signed [rme_pkg::ZW-1:0] z_r [0:N];
  logic                          zf_r [0:N];
  logic signed [rme_pkg::ZW-1:0] zsum;

  // pre-rotate the left half-plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[0] <= (a_in == '0) && (b_in == '0);
      if (b_in < 0) begin
        if (a_in >= 0) begin
          x_r[0] <= a_in;
          y_r[0] <= -b_in;
          z_r[0] <= rme_pkg::HALF_PI_Q24;
        end else begin
          x_r[0] <= -a_in;
          y_r[0] <= b_in;
          z_r[0] <= -rme_pkg::HALF_PI_Q24;
        end
      end else begin
        x_r[0] <= b_in;
        y_r[0] <= a_in;
        z_r[0] <= '0;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_iter
      always_ff @(posedge clk) begin
        if (en) begin
          zf_r[i+1] <= zf_r[i];
          if (!y_r[i][W-1]) begin
            x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
            y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
            z_r[i+1] <= z_r[i] + rme_pkg::atan_q24(i);
          end else begin
            x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
            y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
            z_r[i+1] <= z_r[i] - rme_pkg::atan_q24(i);
          end
        end
      end
    end
  endgenerate

  assign zsum = z_r[N] + 28'sd1024;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= zf_r[N] ? '0 : rme_pkg::QW'(zsum >>> 11);
    end
  end

endmodule

// ===== rtl/rotation_matrix_to_euler.sv =====
// Path from input beat to output beat: 2 operand stages, 29-stage square root,
// 27-stage CORDIC, output register.
// Throughput: one matrix per cycle; the three CORDIC pipelines run side by side.
// The pipeline holds under output back-pressure only when its last stage is full.
// Reset (synchronous, active low) empties the pipeline and sets the threshold to 16351.
module rotation_matrix_to_euler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [14:0]  cfg_wdata,   // pole_threshold
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,    // r00, r02, r10, r11, r12, r20, r22
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,   // angle_x, angle_y, angle_z, zero pad
  output logic [1:0]   out_tuser    // pole_case
);

  localparam int D  = rme_pkg::PIPE_DEPTH;
  localparam int NS = rme_pkg::SQRT_STAGES;
  localparam int NC = rme_pkg::CORDIC_LAT;
  localparam int W  = rme_pkg::CW;

  logic [14:0]          thresh_r;
  logic [D-1:0]         vld_r;
  logic                 adv;
  logic                 out_valid_r;
  logic signed [15:0]   r00, r02, r10, r11, r12, r20, r22;
  logic signed [16:0]   th;
  rme_pkg::opnd_t       s1_nxt, s1_r, s2_r;
  rme_pkg::opnd_t       dly_r [0:NS-1];
  rme_pkg::pole_t       pole_dly_r [0:NC-1];
  logic signed [31:0]   sq;
  logic signed [31:0]   rad_full;
  logic [28:0]          rad_r;
  logic [28:0]          root;
  logic signed [W-1:0]  xa_s, xb_s, za_s, zb_s, ya_s, yb_s;
  logic signed [rme_pkg::QW-1:0] qx, qy, qz;
  logic signed [15:0]   ax_r, az_r;
  logic signed [14:0]   ay_r;
  rme_pkg::pole_t       pole_r;

  assign {r22, r20, r12, r11, r10, r02, r00} = in_tdata;
  assign th = 17'($signed({2'b00, thresh_r}));

  assign adv       = !vld_r[D-1] || !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= rme_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[D-2:0], in_tvalid};
    end
  end

  always_comb begin
    s1_nxt.xa  = -17'(r12);
    s1_nxt.xb  = 17'(r11);
    s1_nxt.r10 = r10;
    if (17'(r10) > th) begin
      s1_nxt.pole = rme_pkg::POLE_NORTH;
    end else if (17'(r10) < -th) begin
      s1_nxt.pole = rme_pkg::POLE_SOUTH;
    end else begin
      s1_nxt.pole = rme_pkg::POLE_NONE;
    end
    if (s1_nxt.pole != rme_pkg::POLE_NONE) begin
      s1_nxt.za = 17'(r02);
      s1_nxt.zb = 17'(r22);
    end else begin
      s1_nxt.za = -17'(r20);
      s1_nxt.zb = 17'(r00);
    end
  end

  assign sq       = s1_r.r10 * s1_r.r10;
  assign rad_full = $signed(rme_pkg::ONE_Q28) - sq;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s1_r;
      rad_r <= rad_full[31] ? '0 : rad_full[28:0];
      dly_r[0] <= s2_r;
      for (int k = 1; k < NS; k++) dly_r[k] <= dly_r[k-1];
      pole_dly_r[0] <= dly_r[NS-1].pole;
      for (int k = 1; k < NC; k++) pole_dly_r[k] <= pole_dly_r[k-1];
    end
  end

  rme_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (rad_r),
    .root (root)
  );

  // Q1.14 operands and the Q.28 root both land on 2^48 per unit
  assign xa_s = W'(dly_r[NS-1].xa) <<< 34;
  assign xb_s = W'(dly_r[NS-1].xb) <<< 34;
  assign za_s = W'(dly_r[NS-1].za) <<< 34;
  assign zb_s = W'(dly_r[NS-1].zb) <<< 34;
  assign ya_s = W'(dly_r[NS-1].r10) <<< 34;
  assign yb_s = $signed(W'(root)) <<< 20;

  rme_cordic u_cordic_x (.clk(clk), .en(adv), .a_in(xa_s), .b_in(xb_s), .q(qx));
  rme_cordic u_cordic_y (.clk(clk), .en(adv), .a_in(ya_s), .b_in(yb_s), .q(qy));
  rme_cordic u_cordic_z (.clk(clk), .en(adv), .a_in(za_s), .b_in(zb_s), .q(qz));

  // output register: apply pole overrides and clamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= vld_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[D-1] && (!out_valid_r || out_tready)) begin
      pole_r <= pole_dly_r[NC-1];
      az_r   <= 16'(rme_pkg::clamp_q(qz, rme_pkg::PI_Q13));
      unique case (pole_dly_r[NC-1])
        rme_pkg::POLE_NORTH: begin
          ax_r <= '0;
          ay_r <= 15'(rme_pkg::HALF_PI_Q13);
        end
        rme_pkg::POLE_SOUTH: begin
          ax_r <= '0;
          ay_r <= 15'(-rme_pkg::HALF_PI_Q13);
        end
        default: begin
          ax_r <= 16'(rme_pkg::clamp_q(qx, rme_pkg::PI_Q13));
          ay_r <= 15'(rme_pkg::clamp_q(qy, rme_pkg::HALF_PI_Q13));
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, az_r, ay_r, ax_r};
  assign out_tuser  = pole_r;

endmodule

// ===== rtl/rme_checker.sv =====
// Port-level checks for the rotation-matrix-to-Euler block, bound to its top level.
module rme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_pole_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == rme_pkg::POLE_NONE || out_tuser == rme_pkg::POLE_NORTH
                   || out_tuser == rme_pkg::POLE_SOUTH)
    else $error("bad pole code");

  a_pole_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rme_pkg::POLE_NONE |-> out_tdata[15:0] == 16'd0)
    else $error("angle_x not zero at a pole");

  a_north_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rme_pkg::POLE_NORTH
      |-> out_tdata[30:16] == 15'(rme_pkg::HALF_PI_Q13))
    else $error("angle_y not +pi/2 at north pole");

endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (.*);
